// ===== src/pgdb_pkg.sv =====
// package for the gray dither pixel converter: modes, stage payload types,
// config register indexes and the 16x16 dither threshold matrix
// no dependencies
package pgdb_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND = 1'd1;

	localparam logic [2:0] BPP_GRAY = 3'd1;
	localparam logic [2:0] BPP_565  = 3'd2;
	localparam logic [2:0] BPP_RGB  = 3'd3;
	localparam logic [2:0] BPP_RGBA = 3'd4;

	// reciprocal of 17 scaled by 4096, exact for 8-bit values
	localparam logic [7:0] RECIP_17 = 8'd241;

	typedef enum logic [2:0] {
		MODE_SKIP,
		MODE_GRAY_PLAIN,
		MODE_GRAY_BLEND,
		MODE_DITHER_PLAIN,
		MODE_DITHER_BLEND
	} mode_t;

	typedef struct packed {
		logic [7:0] src_byte0;
		logic [7:0] src_byte1;
		logic [7:0] src_byte2;
		logic [7:0] src_byte3;
		logic [3:0] row_phase;
		logic [3:0] col_phase;
		logic [7:0] dest_pixel;
	} pix_in_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] gray;
		logic [3:0] level;
		logic [3:0] alpha;
		logic [3:0] row;
		logic [3:0] col;
		logic [7:0] dest;
	} luma_t;

	typedef struct packed {
		mode_t      mode;
		logic [3:0] level;
		logic [3:0] alpha;
		logic [7:0] dest;
	} mix_in_t;

	localparam logic [7:0] DITH_TAB [256] = '{
		8'd0, 8'd235, 8'd59, 8'd219, 8'd15, 8'd231, 8'd55, 8'd215,
		8'd2, 8'd232, 8'd56, 8'd217, 8'd12, 8'd229, 8'd52, 8'd213,
		8'd128, 8'd64, 8'd187, 8'd123, 8'd143, 8'd79, 8'd183, 8'd119,
		8'd130, 8'd66, 8'd184, 8'd120, 8'd140, 8'd76, 8'd180, 8'd116,
		8'd33, 8'd192, 8'd16, 8'd251, 8'd47, 8'd207, 8'd31, 8'd247,
		8'd34, 8'd194, 8'd18, 8'd248, 8'd44, 8'd204, 8'd28, 8'd244,
		8'd161, 8'd97, 8'd144, 8'd80, 8'd175, 8'd111, 8'd159, 8'd95,
		8'd162, 8'd98, 8'd146, 8'd82, 8'd172, 8'd108, 8'd156, 8'd92,
		8'd8, 8'd225, 8'd48, 8'd208, 8'd5, 8'd239, 8'd63, 8'd223,
		8'd10, 8'd226, 8'd50, 8'd210, 8'd6, 8'd236, 8'd60, 8'd220,
		8'd136, 8'd72, 8'd176, 8'd112, 8'd133, 8'd69, 8'd191, 8'd127,
		8'd138, 8'd74, 8'd178, 8'd114, 8'd134, 8'd70, 8'd188, 8'd124,
		8'd41, 8'd200, 8'd24, 8'd240, 8'd36, 8'd197, 8'd20, 8'd255,
		8'd42, 8'd202, 8'd26, 8'd242, 8'd38, 8'd198, 8'd22, 8'd252,
		8'd169, 8'd105, 8'd152, 8'd88, 8'd164, 8'd100, 8'd148, 8'd84,
		8'd170, 8'd106, 8'd154, 8'd90, 8'd166, 8'd102, 8'd150, 8'd86,
		8'd3, 8'd233, 8'd57, 8'd216, 8'd13, 8'd228, 8'd53, 8'd212,
		8'd1, 8'd234, 8'd58, 8'd218, 8'd14, 8'd230, 8'd54, 8'd214,
		8'd131, 8'd67, 8'd185, 8'd121, 8'd141, 8'd77, 8'd181, 8'd117,
		8'd129, 8'd65, 8'd186, 8'd122, 8'd142, 8'd78, 8'd182, 8'd118,
		8'd35, 8'd195, 8'd19, 8'd249, 8'd45, 8'd205, 8'd29, 8'd245,
		8'd32, 8'd193, 8'd17, 8'd250, 8'd46, 8'd206, 8'd30, 8'd246,
		8'd163, 8'd99, 8'd147, 8'd83, 8'd173, 8'd109, 8'd157, 8'd93,
		8'd160, 8'd96, 8'd145, 8'd81, 8'd174, 8'd110, 8'd158, 8'd94,
		8'd11, 8'd227, 8'd51, 8'd211, 8'd7, 8'd237, 8'd61, 8'd221,
		8'd9, 8'd224, 8'd49, 8'd209, 8'd4, 8'd238, 8'd62, 8'd222,
		8'd139, 8'd75, 8'd179, 8'd115, 8'd135, 8'd71, 8'd189, 8'd125,
		8'd137, 8'd73, 8'd177, 8'd113, 8'd132, 8'd68, 8'd190, 8'd126,
		8'd43, 8'd203, 8'd27, 8'd243, 8'd39, 8'd199, 8'd23, 8'd253,
		8'd40, 8'd201, 8'd25, 8'd241, 8'd37, 8'd196, 8'd21, 8'd254,
		8'd171, 8'd107, 8'd155, 8'd91, 8'd167, 8'd103, 8'd151, 8'd87,
		8'd168, 8'd104, 8'd153, 8'd89, 8'd165, 8'd101, 8'd149, 8'd85
	};

endpackage

// ===== src/pgdb_pixel_if.sv =====
// source pixel channel: valid/ready handshake with the source bytes,
// dither phases and destination byte; no dependencies
interface pgdb_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_byte0;
	logic [7:0] src_byte1;
	logic [7:0] src_byte2;
	logic [7:0] src_byte3;
	logic [3:0] row_phase;
	logic [3:0] col_phase;
	logic [7:0] dest_pixel;

	modport source (
		output valid, src_byte0, src_byte1, src_byte2, src_byte3,
		output row_phase, col_phase, dest_pixel,
		input  ready
	);
	modport sink (
		input  valid, src_byte0, src_byte1, src_byte2, src_byte3,
		input  row_phase, col_phase, dest_pixel,
		output ready
	);
endinterface

// ===== src/pgdb_result_if.sv =====
// result channel: valid/ready handshake with the new destination byte
// and its write enable; no dependencies
interface pgdb_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_pixel;
	logic       write_enable;

	modport source (output valid, out_pixel, write_enable, input ready);
	modport sink (input valid, out_pixel, write_enable, output ready);
endinterface

// ===== src/pixel_gray_dither_blend.sv =====
// top level of the gray dither pixel converter: config registers and the
// four-stage pipeline; depends on pgdb_pkg, the two channel interfaces,
// pgdb_luma, pgdb_quant and pgdb_mix
//
//   channel   dir   handshake      contents
//   pixel     in    valid/ready    src_byte0..3, row_phase, col_phase, dest_pixel
//   result    out   valid/ready    out_pixel, write_enable
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// one item per cycle while the result side is not stalled; the registered
// stages are luma, divide, dither and blend/output register
// each stage holds its item while the next one is full and stalled,
// so bubbles are squeezed out while the result waits
// reset clears the valid bits and sets bytes_per_pixel 4, blend off
module pixel_gray_dither_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pgdb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pgdb_pkg::CFG_DATA_W-1:0] cfg_data,
	pgdb_pixel_if.sink                    pixel,
	pgdb_result_if.source                 result
);
	import pgdb_pkg::*;

	logic [2:0] bpp_q;
	logic       blend_q;
	pix_in_t    pix_in;
	logic       v_luma;
	logic       r_luma;
	luma_t      d_luma;
	logic       v_quant;
	logic       r_quant;
	mix_in_t    d_quant;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= BPP_RGBA;
			blend_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BPP:   bpp_q   <= cfg_data[2:0];
				CFG_BLEND: blend_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pix_in.src_byte0  = pixel.src_byte0;
	assign pix_in.src_byte1  = pixel.src_byte1;
	assign pix_in.src_byte2  = pixel.src_byte2;
	assign pix_in.src_byte3  = pixel.src_byte3;
	assign pix_in.row_phase  = pixel.row_phase;
	assign pix_in.col_phase  = pixel.col_phase;
	assign pix_in.dest_pixel = pixel.dest_pixel;

	pgdb_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.bpp       (bpp_q),
		.blend     (blend_q),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.in_data   (pix_in),
		.out_valid (v_luma),
		.out_ready (r_luma),
		.out_data  (d_luma)
	);

	pgdb_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_luma),
		.in_ready  (r_luma),
		.in_data   (d_luma),
		.out_valid (v_quant),
		.out_ready (r_quant),
		.out_data  (d_quant)
	);

	pgdb_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (v_quant),
		.in_ready     (r_quant),
		.in_data      (d_quant),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_pixel    (result.out_pixel),
		.write_enable (result.write_enable)
	);
endmodule

// ===== src/pgdb_luma.sv =====
// stage 1: format decode, rgb565 unpack and luma sum
// depends on pgdb_pkg
module pgdb_luma (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      bpp,
	input  logic            blend,
	input  logic            in_valid,
	output logic            in_ready,
	input  pgdb_pkg::pix_in_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output pgdb_pkg::luma_t out_data
);
	import pgdb_pkg::*;

	mode_t       mode;
	logic [7:0]  r;
	logic [7:0]  g;
	logic [7:0]  b;
	logic [17:0] sum;
	logic        v_s1;
	luma_t       d_s1;

	always_comb begin
		if (blend && bpp == BPP_GRAY) begin
			mode = MODE_GRAY_BLEND;
		end else if (blend && bpp == BPP_RGBA) begin
			mode = (in_data.src_byte3 != 8'd0) ? MODE_DITHER_BLEND : MODE_SKIP;
		end else if (bpp == BPP_GRAY) begin
			mode = MODE_GRAY_PLAIN;
		end else if (bpp == BPP_565 || bpp == BPP_RGB || bpp == BPP_RGBA) begin
			mode = MODE_DITHER_PLAIN;
		end else begin
			mode = MODE_SKIP;
		end
	end

	always_comb begin
		if (bpp == BPP_565) begin
			r = {in_data.src_byte0[7:3], 3'b000};
			g = {in_data.src_byte0[2:0], in_data.src_byte1[7:5], 2'b00};
			b = {in_data.src_byte1[4:0], 3'b000};
		end else begin
			r = in_data.src_byte2;
			g = in_data.src_byte1;
			b = in_data.src_byte0;
		end
	end

	assign sum = 18'(r) * 18'd306 + 18'(g) * 18'd601 + 18'(b) * 18'd117;

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s1.mode  <= mode;
			d_s1.gray  <= sum[17:10];
			d_s1.level <= in_data.src_byte0[7:4];
			d_s1.alpha <= (bpp == BPP_GRAY) ? in_data.src_byte0[3:0]
				: in_data.src_byte3[7:4];
			d_s1.row   <= in_data.row_phase;
			d_s1.col   <= in_data.col_phase;
			d_s1.dest  <= in_data.dest_pixel;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;
endmodule

// ===== src/pgdb_quant.sv =====
// stages 2 and 3: divide by 17 and threshold lookup, then ordered dither
// compare that picks the 4-bit level in the dither modes; depends on pgdb_pkg
module pgdb_quant (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pgdb_pkg::luma_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pgdb_pkg::mix_in_t out_data
);
	import pgdb_pkg::*;

	logic [15:0] prod;
	logic        v_s2;
	mode_t       mode_s2;
	logic [7:0]  gray_s2;
	logic [3:0]  level_s2;
	logic [3:0]  alpha_s2;
	logic [7:0]  dest_s2;
	logic [3:0]  q_s2;
	logic [7:0]  thr_s2;
	logic        rdy_s2;
	logic        rdy_s3;
	logic [4:0]  rem;
	logic [7:0]  scaled;
	logic        bump;
	logic [3:0]  level;
	logic        v_s3;
	mix_in_t     d_s3;

	assign prod = 16'(in_data.gray) * 16'(RECIP_17);

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s2) begin
			mode_s2  <= in_data.mode;
			gray_s2  <= in_data.gray;
			level_s2 <= in_data.level;
			alpha_s2 <= in_data.alpha;
			dest_s2  <= in_data.dest;
			q_s2     <= prod[15:12];
			thr_s2   <= DITH_TAB[{in_data.row, in_data.col}];
		end
	end

	// remainder is 0..16; scaled is exactly 15 times it, close to 256/17 times it
	assign rem    = 5'(gray_s2 - {q_s2, 4'b0000} - 8'(q_s2));
	assign scaled = 8'(9'({rem, 4'b0000}) - 9'(rem));
	assign bump   = (q_s2 != 4'hF) && (scaled > thr_s2);

	always_comb begin
		if (mode_s2 == MODE_DITHER_PLAIN || mode_s2 == MODE_DITHER_BLEND) begin
			level = q_s2 + 4'(bump);
		end else begin
			level = level_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			d_s3.mode  <= mode_s2;
			d_s3.level <= level;
			d_s3.alpha <= alpha_s2;
			d_s3.dest  <= dest_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;
endmodule

// ===== src/pgdb_mix.sv =====
// stage 4: inversion, alpha blend against the destination nibble and
// output register; depends on pgdb_pkg
module pgdb_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pgdb_pkg::mix_in_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_pixel,
	output logic              write_enable
);
	import pgdb_pkg::*;

	logic [3:0] inv;
	logic [7:0] p_src;
	logic [7:0] p_dst;
	logic [4:0] blend_sum;
	logic [3:0] c;
	logic [7:0] pix;
	logic       we;
	logic       v_s4;
	logic [7:0] pix_s4;
	logic       we_s4;

	assign inv       = 4'hF - in_data.level;
	assign p_src     = 8'(inv) * 8'(in_data.alpha);
	assign p_dst     = 8'(in_data.dest[7:4]) * 8'(4'hF - in_data.alpha);
	assign blend_sum = 5'(p_src[7:4]) + 5'(p_dst[7:4]);
	assign c         = (in_data.alpha == 4'hF) ? inv : blend_sum[3:0];

	always_comb begin
		case (in_data.mode) inside
			MODE_GRAY_PLAIN, MODE_DITHER_PLAIN: begin
				pix = {inv, 4'hF};
				we  = 1'b1;
			end
			MODE_GRAY_BLEND, MODE_DITHER_BLEND: begin
				pix = {c, in_data.dest[3:0]};
				we  = 1'b1;
			end
			default: begin
				pix = in_data.dest;
				we  = 1'b0;
			end
		endcase
	end

	assign in_ready = !v_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pix_s4 <= pix;
			we_s4  <= we;
		end
	end

	assign out_valid    = v_s4;
	assign out_pixel    = pix_s4;
	assign write_enable = we_s4;
endmodule

// ===== src/pgdb_checker.sv =====
// port-level checks for pixel_gray_dither_blend and the bind that attaches
// them; depends on pixel_gray_dither_blend
module pgdb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_pixel,
	input logic       write_enable
);
	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(out_pixel) && $stable(write_enable))
		else $error("result changed while stalled");

	// an accepted item reaches the output through the luma, divide, dither and output registers when the output drains
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_acc, 4) && $past(arst_n, 1) && $past(arst_n, 2) &&
		$past(arst_n, 3) && $past(arst_n, 4) && $past(out_ready, 1) &&
		$past(out_ready, 2) && $past(out_ready, 3) |-> out_valid)
		else $error("item missing at expected latency");

	// no item without an accept once the pipeline has drained
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) &&
		!$past(in_acc, 4) && $past(out_ready, 1) && $past(out_ready, 2) &&
		$past(out_ready, 3) && $past(out_ready, 4) |-> !out_valid)
		else $error("result with no item in flight");
endmodule

bind pixel_gray_dither_blend pgdb_checker u_pgdb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pixel.valid),
	.in_ready     (pixel.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_pixel    (result.out_pixel),
	.write_enable (result.write_enable)
);
